// ----- sv/pbbt_pkg.sv -----
// ============================================================================
// Pool byte budget tracker package
// Sizes, command and priority codes, register indexes and the small helper
// functions of the tracker; its checker and the testbench use it too.
// ============================================================================
`default_nettype none

package pbbt_pkg;

    localparam int POOL_COUNT   = 7;
    localparam int BYTE_WIDTH   = 48;
    localparam int COUNT_WIDTH  = 32;
    localparam int DURABLE_POOL = POOL_COUNT - 1;
    localparam int POOL_IDX_W   = $clog2(POOL_COUNT);
    localparam int CFG_IDX_W    = $clog2(POOL_COUNT + 1);
    localparam int SHED_PCT     = 85;
    localparam int FULL_PCT     = 100;
    // 100 * BYTE_WIDTH-bit value fits in BYTE_WIDTH + 7 bits.
    localparam int SCALED_W     = BYTE_WIDTH + 7;

    typedef logic [BYTE_WIDTH-1:0]  t_bytes;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [SCALED_W-1:0]    t_scaled;
    typedef logic [POOL_IDX_W-1:0]  t_pidx;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;

    // Command codes; the two unused codes behave as a query.
    localparam logic [2:0] CMD_TRY_RESERVE = 3'd0;
    localparam logic [2:0] CMD_RESERVE     = 3'd1;
    localparam logic [2:0] CMD_RELEASE     = 3'd2;
    localparam logic [2:0] CMD_EVICT       = 3'd3;
    localparam logic [2:0] CMD_SHED        = 3'd4;
    localparam logic [2:0] CMD_QUERY       = 3'd5;

    localparam logic [1:0] PRIO_INTERACTION = 2'd0;
    localparam logic [1:0] PRIO_VISIBLE     = 2'd1;
    localparam logic [1:0] PRIO_PREFETCH    = 2'd2;
    localparam logic [1:0] PRIO_BACKGROUND  = 2'd3;

    localparam logic [1:0] PRESS_NORMAL   = 2'd0;
    localparam logic [1:0] PRESS_SHEDDING = 2'd1;
    localparam logic [1:0] PRESS_HARD     = 2'd2;

    // Register 0 is the resident limit; registers 1.. are the pool limits.
    localparam t_cfg_idx CFG_RESIDENT_LIMIT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_POOL_BASE      = t_cfg_idx'(1);

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + t_count'(1);
    endfunction

    // 100 * v, built from shifts and adds.
    function automatic t_scaled times_full(input t_bytes v);
        t_scaled w;
        w = t_scaled'(v);
        return (w << 6) + (w << 5) + (w << 2);
    endfunction

    // u >= floor(85 * L / 100) holds exactly when 100 * u >= 85 * L - 99.
    // This returns the right side, clamped at zero.
    function automatic t_scaled shed_bound(input t_bytes v);
        t_scaled w;
        t_scaled p;
        w = t_scaled'(v);
        p = (w << 6) + (w << 4) + (w << 2) + w;
        return (p >= t_scaled'(FULL_PCT - 1)) ? p - t_scaled'(FULL_PCT - 1) : '0;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pool_byte_budget_tracker_unit.sv -----
// ============================================================================
// Pool byte budget tracker
// Byte accounting for a set of pools with per-pool limits, a shared resident
// limit, saturating event counters and a three-level pressure indication.
// ============================================================================
// The tracker takes one command beat per clock unless the output stalls,
// and returns one result beat per command, in order. The result passes the
// execute and pressure stages before it appears on the result ports.
// Throughput is one command per cycle unless the output stalls: all pool
// counters live in flip-flops and the whole read-modify-write of a command
// completes in the execute stage, so the next command always sees the
// updated counters. The pressure level is evaluated in the output stage
// from the counters as they stand after the command, with every non-durable
// pool with a nonzero limit compared against its threshold in parallel. A
// stall on the output freezes all three stages and the counters together,
// and it is passed straight back to the input as stall. Configuration writes
// are always ready and take effect at the write edge; they are meant to be
// issued while no command is in flight.
// ============================================================================
`default_nettype none

module pool_byte_budget_tracker_unit (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Command channel
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [2:0]             i_cmd,
    input  wire  [2:0]             i_pool,
    input  wire  pbbt_pkg::t_bytes i_amount,
    input  wire  [1:0]             i_priority_req,
    // Result channel
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic                   o_granted,
    output pbbt_pkg::t_bytes       o_pool_used,
    output pbbt_pkg::t_bytes       o_pool_peak,
    output pbbt_pkg::t_count       o_pool_evict_count,
    output pbbt_pkg::t_count       o_pool_shed_count,
    output pbbt_pkg::t_bytes       o_pool_cap,
    output pbbt_pkg::t_bytes       o_resident_used,
    output pbbt_pkg::t_bytes       o_resident_peak,
    output pbbt_pkg::t_count       o_prefetch_shed_total,
    output logic [1:0]             o_pressure_level,
    // Configuration write channel
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  pbbt_pkg::t_cfg_idx i_cfg_index,
    input  wire  pbbt_pkg::t_bytes i_cfg_data
);
    import pbbt_pkg::*;

    // Limits and their precomputed shedding bounds.
    t_bytes  r_resident_limit;
    t_scaled r_resident_bound;
    t_bytes  r_pool_limit [POOL_COUNT];
    t_scaled r_pool_bound [POOL_COUNT];

    // Accounting state.
    t_bytes  r_used  [POOL_COUNT];
    t_bytes  r_peak  [POOL_COUNT];
    t_count  r_evict [POOL_COUNT];
    t_count  r_shed  [POOL_COUNT];
    t_bytes  r_total;
    t_bytes  r_high;
    t_count  r_pf_sheds;

    // Input stage.
    logic       r_in_vld;
    logic [2:0] r_in_cmd;
    logic [2:0] r_in_pool;
    t_bytes     r_in_amount;
    logic [1:0] r_in_prio;

    // Execute result stage.
    logic   r_s2_vld;
    logic   r_s2_granted;
    t_bytes r_s2_used;
    t_bytes r_s2_peak;
    t_count r_s2_evict;
    t_count r_s2_shed;
    t_bytes r_s2_cap;
    t_bytes r_s2_total;
    t_bytes r_s2_high;
    t_count r_s2_pf;

    // Output stage.
    logic       r_out_vld;
    logic       r_out_granted;
    t_bytes     r_out_used;
    t_bytes     r_out_peak;
    t_count     r_out_evict;
    t_count     r_out_shed;
    t_bytes     r_out_cap;
    t_bytes     r_out_total;
    t_bytes     r_out_high;
    t_count     r_out_pf;
    logic [1:0] r_out_press;

    // The whole pipeline moves as one whenever the output slot can advance.
    logic advance;
    assign advance     = !r_out_vld || !i_out_stall;
    assign o_in_stall  = !advance;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Execute: one read-modify-write of the addressed pool.
    // ------------------------------------------------------------------
    logic                pool_ok;
    logic                durable;
    t_pidx               p;
    t_bytes              cur_used;
    t_bytes              cur_lim;
    logic [BYTE_WIDTH:0] pool_sum;
    logic [BYTE_WIDTH:0] res_sum;
    logic                fits;
    t_bytes              rel;
    logic                exe;
    logic                n_granted;
    t_bytes              n_used;
    t_bytes              n_peak;
    t_count              n_evict;
    t_count              n_shed;
    t_bytes              n_total;
    t_bytes              n_high;
    t_count              n_pf;

    always_comb begin
        pool_ok  = int'(r_in_pool) < POOL_COUNT;
        durable  = pool_ok && (int'(r_in_pool) == DURABLE_POOL);
        p        = pool_ok ? t_pidx'(r_in_pool) : '0;
        cur_used = r_used[p];
        cur_lim  = r_pool_limit[p];
        pool_sum = {1'b0, cur_used} + {1'b0, r_in_amount};
        res_sum  = {1'b0, r_total} + {1'b0, r_in_amount};
        // A reserve must keep the pool limit, and the resident limit too
        // unless the pool is the durable one. A zero reserve always passes.
        fits = (r_in_amount == '0) ||
               ((pool_sum <= {1'b0, cur_lim}) &&
                (durable || (res_sum <= {1'b0, r_resident_limit})));
        rel  = (r_in_amount < cur_used) ? r_in_amount : cur_used;
        exe  = advance && r_in_vld && pool_ok;

        n_granted = pool_ok;
        n_used    = cur_used;
        n_peak    = r_peak[p];
        n_evict   = r_evict[p];
        n_shed    = r_shed[p];
        n_total   = r_total;
        n_high    = r_high;
        n_pf      = r_pf_sheds;

        if (pool_ok) begin
            case (r_in_cmd) inside
                CMD_TRY_RESERVE, CMD_RESERVE: begin
                    n_granted = fits;
                    if (fits) begin
                        n_used = pool_sum[BYTE_WIDTH-1:0];
                        if (n_used > n_peak) begin
                            n_peak = n_used;
                        end
                        if (!durable) begin
                            n_total = res_sum[BYTE_WIDTH-1:0];
                            if (n_total > n_high) begin
                                n_high = n_total;
                            end
                        end
                    end else if (r_in_cmd == CMD_TRY_RESERVE) begin
                        // Refused low-priority work counts as shed.
                        if (r_in_prio == PRIO_PREFETCH || r_in_prio == PRIO_BACKGROUND) begin
                            n_shed = sat_inc(n_shed);
                        end
                        if (r_in_prio == PRIO_PREFETCH) begin
                            n_pf = sat_inc(n_pf);
                        end
                    end
                end
                CMD_RELEASE: begin
                    n_used = cur_used - rel;
                    if (!durable) begin
                        n_total = r_total - ((rel < r_total) ? rel : r_total);
                    end
                end
                CMD_EVICT: begin
                    n_evict = sat_inc(n_evict);
                end
                CMD_SHED: begin
                    n_shed = sat_inc(n_shed);
                    if (r_in_prio == PRIO_PREFETCH) begin
                        n_pf = sat_inc(n_pf);
                    end
                end
                default: begin
                    // Query and the unused codes leave the state alone.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pressure from the counters as they stand after the command that sits
    // in the execute result stage.
    // ------------------------------------------------------------------
    logic       pool_hot;
    logic [1:0] pressure;

    always_comb begin
        pool_hot = 1'b0;
        for (int i = 0; i < POOL_COUNT; i++) begin
            if (i != DURABLE_POOL && r_pool_limit[i] != '0 &&
                times_full(r_used[i]) >= r_pool_bound[i]) begin
                pool_hot = 1'b1;
            end
        end
        if (r_resident_limit == '0 || r_total >= r_resident_limit) begin
            pressure = PRESS_HARD;
        end else if (times_full(r_total) >= r_resident_bound || pool_hot) begin
            pressure = PRESS_SHEDDING;
        end else begin
            pressure = PRESS_NORMAL;
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld         <= 1'b0;
            r_s2_vld         <= 1'b0;
            r_out_vld        <= 1'b0;
            r_resident_limit <= '0;
            r_resident_bound <= '0;
            r_total          <= '0;
            r_high           <= '0;
            r_pf_sheds       <= '0;
            for (int i = 0; i < POOL_COUNT; i++) begin
                r_pool_limit[i] <= '0;
                r_pool_bound[i] <= '0;
                r_used[i]       <= '0;
                r_peak[i]       <= '0;
                r_evict[i]      <= '0;
                r_shed[i]       <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RESIDENT_LIMIT) begin
                    r_resident_limit <= i_cfg_data;
                    r_resident_bound <= shed_bound(i_cfg_data);
                end else begin
                    for (int i = 0; i < POOL_COUNT; i++) begin
                        if (int'(i_cfg_index) == int'(CFG_POOL_BASE) + i) begin
                            r_pool_limit[i] <= i_cfg_data;
                            r_pool_bound[i] <= shed_bound(i_cfg_data);
                        end
                    end
                end
            end

            if (advance) begin
                r_in_vld  <= i_in_valid;
                r_s2_vld  <= r_in_vld;
                r_out_vld <= r_s2_vld;
            end

            if (exe) begin
                r_used[p]  <= n_used;
                r_peak[p]  <= n_peak;
                r_evict[p] <= n_evict;
                r_shed[p]  <= n_shed;
                r_total    <= n_total;
                r_high     <= n_high;
                r_pf_sheds <= n_pf;
            end
        end

        // Payload registers carry no reset.
        if (advance) begin
            if (i_in_valid) begin
                r_in_cmd    <= i_cmd;
                r_in_pool   <= i_pool;
                r_in_amount <= i_amount;
                r_in_prio   <= i_priority_req;
            end
            if (r_in_vld) begin
                r_s2_granted <= n_granted;
                r_s2_used    <= pool_ok ? n_used  : '0;
                r_s2_peak    <= pool_ok ? n_peak  : '0;
                r_s2_evict   <= pool_ok ? n_evict : '0;
                r_s2_shed    <= pool_ok ? n_shed  : '0;
                r_s2_cap     <= pool_ok ? cur_lim : '0;
                r_s2_total   <= n_total;
                r_s2_high    <= n_high;
                r_s2_pf      <= n_pf;
            end
            if (r_s2_vld) begin
                r_out_granted <= r_s2_granted;
                r_out_used    <= r_s2_used;
                r_out_peak    <= r_s2_peak;
                r_out_evict   <= r_s2_evict;
                r_out_shed    <= r_s2_shed;
                r_out_cap     <= r_s2_cap;
                r_out_total   <= r_s2_total;
                r_out_high    <= r_s2_high;
                r_out_pf      <= r_s2_pf;
                r_out_press   <= pressure;
            end
        end
    end

    assign o_out_valid           = r_out_vld;
    assign o_granted             = r_out_granted;
    assign o_pool_used           = r_out_used;
    assign o_pool_peak           = r_out_peak;
    assign o_pool_evict_count    = r_out_evict;
    assign o_pool_shed_count     = r_out_shed;
    assign o_pool_cap            = r_out_cap;
    assign o_resident_used       = r_out_total;
    assign o_resident_peak       = r_out_high;
    assign o_prefetch_shed_total = r_out_pf;
    assign o_pressure_level      = r_out_press;

endmodule

`default_nettype wire

// ----- sv/pbbt_checker.sv -----
// ============================================================================
// Pool byte budget tracker checker
// Port-level assertions on the tracker, attached by a bind statement.
// ============================================================================
`default_nettype none

module pbbt_checker (
    input wire                      i_clk,
    input wire                      i_rst_n,
    input wire                      o_in_stall,
    input wire                      o_out_valid,
    input wire                      i_out_stall,
    input wire                      o_granted,
    input wire  pbbt_pkg::t_bytes   o_pool_used,
    input wire  pbbt_pkg::t_bytes   o_pool_peak,
    input wire  pbbt_pkg::t_bytes   o_resident_used,
    input wire  pbbt_pkg::t_bytes   o_resident_peak,
    input wire  [1:0]               o_pressure_level
);

    // The high-water mark of a pool never sits below its current use.
    a_pool_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_pool_used <= o_pool_peak)
        else $error("pool peak below pool use");

    // The same holds for the resident total.
    a_resident_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_resident_used <= o_resident_peak)
        else $error("resident peak below resident use");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_pool_used) && $stable(o_resident_used) &&
            $stable(o_granted) && $stable(o_pressure_level))
        else $error("stalled result changed");

    // The command side is only held off by a waiting, stalled result.
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("command stall without a stalled result");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind pool_byte_budget_tracker_unit pbbt_checker u_pbbt_checker (.*);

`default_nettype wire

// ----- verif/tb.sv -----
// ============================================================================
// Pool byte budget tracker testbench
// Self-checking bench for the tracker. A behavioral copy of the accounting
// rules predicts every result beat; a checker compares each one field by
// field. Directed cases come first, then phases of random traffic under
// several limit settings, with random idle cycles on both channels.
// ============================================================================

module tb;

    import pbbt_pkg::*;

    // The two spare command codes behave as a query.
    localparam logic [2:0] CMD_SPARE_6  = 3'd6;
    localparam logic [2:0] CMD_SPARE_7  = 3'd7;
    // Pool index past the last pool; the tracker must ignore it.
    localparam logic [2:0] INVALID_POOL = 3'd7;

    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 250;
    // Cycles to let the three-stage pipeline empty before touching registers.
    localparam int DRAIN_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 10;
    // No beat on any channel for this many cycles means the block is stuck.
    localparam int WATCHDOG_LIMIT  = 500;

    // Limit styles used when a random phase picks its register values.
    localparam int LIM_ZERO   = 0;
    localparam int LIM_MAX    = 1;
    localparam int LIM_SMALL  = 2;
    localparam int LIM_WIDE   = 4;

    typedef struct {
        logic       granted;
        t_bytes     pool_used;
        t_bytes     pool_peak;
        t_count     pool_evict_count;
        t_count     pool_shed_count;
        t_bytes     pool_cap;
        t_bytes     resident_used;
        t_bytes     resident_peak;
        t_count     prefetch_shed_total;
        logic [1:0] pressure_level;
    } tracker_report_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input has a known value from
    // time zero.
    // ------------------------------------------------------------------------
    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_cmd          = 3'd0;
    logic [2:0] i_pool         = 3'd0;
    t_bytes     i_amount       = '0;
    logic [1:0] i_priority_req = 2'd0;
    logic       o_out_valid;
    logic       i_out_stall    = 1'b0;
    logic       o_granted;
    t_bytes     o_pool_used;
    t_bytes     o_pool_peak;
    t_count     o_pool_evict_count;
    t_count     o_pool_shed_count;
    t_bytes     o_pool_cap;
    t_bytes     o_resident_used;
    t_bytes     o_resident_peak;
    t_count     o_prefetch_shed_total;
    logic [1:0] o_pressure_level;
    logic       i_cfg_valid    = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index    = '0;
    t_bytes     i_cfg_data     = '0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    pool_byte_budget_tracker_unit u_dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_stall            (o_in_stall),
        .i_cmd                 (i_cmd),
        .i_pool                (i_pool),
        .i_amount              (i_amount),
        .i_priority_req        (i_priority_req),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_granted             (o_granted),
        .o_pool_used           (o_pool_used),
        .o_pool_peak           (o_pool_peak),
        .o_pool_evict_count    (o_pool_evict_count),
        .o_pool_shed_count     (o_pool_shed_count),
        .o_pool_cap            (o_pool_cap),
        .o_resident_used       (o_resident_used),
        .o_resident_peak       (o_resident_peak),
        .o_prefetch_shed_total (o_prefetch_shed_total),
        .o_pressure_level      (o_pressure_level),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predicted tracker state. It mirrors the registers and counters inside
    // the block and is advanced once for every accepted command beat.
    // ------------------------------------------------------------------------
    t_bytes lim_resident;
    t_bytes lim_pool       [POOL_COUNT];
    t_bytes bytes_in_use   [POOL_COUNT];
    t_bytes bytes_peak     [POOL_COUNT];
    t_count evictions      [POOL_COUNT];
    t_count sheds          [POOL_COUNT];
    t_bytes shared_held;
    t_bytes resident_peak_bytes;
    t_count prefetch_drops;

    // Results predicted for accepted commands, oldest first.
    tracker_report_t expected_reports [$];

    // Register values for the next call of program_limits.
    t_bytes next_resident_limit;
    t_bytes next_pool_limit [POOL_COUNT];

    int  mismatches       = 0;
    int  commands_sent    = 0;
    int  reports_checked  = 0;
    int  settings_applied = 0;
    int  idle_cycles      = 0;
    int  stall_left       = 0;
    bit  tx_idle_free     = 1'b0;
    bit  rx_idle_free     = 1'b0;
    tracker_report_t want_rpt;

    function automatic t_count bump(input t_count c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // floor(lim * 85 / 100); the product fits easily in 64 bits.
    function automatic t_bytes shed_line(input t_bytes lim);
        logic [63:0] w;
        w = (64'(lim) * 64'(SHED_PCT)) / 64'(FULL_PCT);
        return t_bytes'(w);
    endfunction

    // Apply one command to the predicted state and build the result that the
    // block must return for it.
    function automatic tracker_report_t account_command(input logic [2:0] cmd,
                                                        input logic [2:0] pool,
                                                        input t_bytes     amt,
                                                        input logic [1:0] prio);
        tracker_report_t rpt;
        bit     pool_ok;
        bit     durable;
        bit     ok;
        int     p;
        t_bytes rel;
        t_bytes lim;
        pool_ok = (pool < POOL_COUNT);
        p       = pool_ok ? int'(pool) : 0;
        durable = (p == DURABLE_POOL);
        ok      = pool_ok;
        if (pool_ok) begin
            case (cmd)
                CMD_TRY_RESERVE, CMD_RESERVE: begin
                    lim = lim_pool[p];
                    // A reserve has to fit under the pool limit and, unless
                    // the pool is durable, under the shared resident limit.
                    if (amt == '0) begin
                        ok = 1'b1;
                    end else if (amt > lim || bytes_in_use[p] > lim - amt) begin
                        ok = 1'b0;
                    end else if (!durable && (amt > lim_resident ||
                                 shared_held > lim_resident - amt)) begin
                        ok = 1'b0;
                    end else begin
                        ok = 1'b1;
                        bytes_in_use[p] = bytes_in_use[p] + amt;
                        if (bytes_in_use[p] > bytes_peak[p])
                            bytes_peak[p] = bytes_in_use[p];
                        if (!durable) begin
                            shared_held = shared_held + amt;
                            if (shared_held > resident_peak_bytes)
                                resident_peak_bytes = shared_held;
                        end
                    end
                    // Only a refused try-reserve at a low priority is a shed.
                    if (!ok && cmd == CMD_TRY_RESERVE) begin
                        if (prio == PRIO_PREFETCH || prio == PRIO_BACKGROUND)
                            sheds[p] = bump(sheds[p]);
                        if (prio == PRIO_PREFETCH)
                            prefetch_drops = bump(prefetch_drops);
                    end
                end
                CMD_RELEASE: begin
                    // A release never takes a pool or the resident total
                    // below zero.
                    rel = (amt < bytes_in_use[p]) ? amt : bytes_in_use[p];
                    bytes_in_use[p] = bytes_in_use[p] - rel;
                    if (!durable)
                        shared_held = shared_held -
                                      ((rel < shared_held) ? rel : shared_held);
                end
                CMD_EVICT: begin
                    evictions[p] = bump(evictions[p]);
                end
                CMD_SHED: begin
                    sheds[p] = bump(sheds[p]);
                    if (prio == PRIO_PREFETCH)
                        prefetch_drops = bump(prefetch_drops);
                end
                default: ;
            endcase
        end

        rpt.granted             = ok;
        rpt.pool_used           = pool_ok ? bytes_in_use[p] : '0;
        rpt.pool_peak           = pool_ok ? bytes_peak[p]   : '0;
        rpt.pool_evict_count    = pool_ok ? evictions[p]    : '0;
        rpt.pool_shed_count     = pool_ok ? sheds[p]        : '0;
        rpt.pool_cap            = pool_ok ? lim_pool[p]     : '0;
        rpt.resident_used       = shared_held;
        rpt.resident_peak       = resident_peak_bytes;
        rpt.prefetch_shed_total = prefetch_drops;

        // Pressure after the command: hard at or over the resident limit
        // (a zero limit is always hard), shedding at 85 percent of the
        // resident limit or of any non-durable pool with a nonzero limit.
        if (lim_resident == '0 || shared_held >= lim_resident) begin
            rpt.pressure_level = PRESS_HARD;
        end else if (shared_held >= shed_line(lim_resident)) begin
            rpt.pressure_level = PRESS_SHEDDING;
        end else begin
            rpt.pressure_level = PRESS_NORMAL;
            for (int i = 0; i < POOL_COUNT; i++) begin
                if (i != DURABLE_POOL && lim_pool[i] != '0 &&
                    bytes_in_use[i] >= shed_line(lim_pool[i]))
                    rpt.pressure_level = PRESS_SHEDDING;
            end
        end
        return rpt;
    endfunction

    // ------------------------------------------------------------------------
    // Result side. The receiver draws a number of stall cycles after every
    // accepted beat; the count runs down whether or not a beat is waiting,
    // so stalls land on every phase of the pipeline.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_out_stall <= (stall_left != 0);
        end else if (o_out_valid) begin
            stall_left = rx_idle_free ? 0 : $urandom_range(0, 15);
            i_out_stall <= (stall_left != 0);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("result beat arrived with no command outstanding");
                mismatches++;
            end else begin
                want_rpt = expected_reports.pop_front();
                reports_checked++;
                check_field("granted", 64'(want_rpt.granted), 64'(o_granted));
                check_field("pool_used", 64'(want_rpt.pool_used), 64'(o_pool_used));
                check_field("pool_peak", 64'(want_rpt.pool_peak), 64'(o_pool_peak));
                check_field("pool_evict_count", 64'(want_rpt.pool_evict_count),
                            64'(o_pool_evict_count));
                check_field("pool_shed_count", 64'(want_rpt.pool_shed_count),
                            64'(o_pool_shed_count));
                check_field("pool_cap", 64'(want_rpt.pool_cap), 64'(o_pool_cap));
                check_field("resident_used", 64'(want_rpt.resident_used),
                            64'(o_resident_used));
                check_field("resident_peak", 64'(want_rpt.resident_peak),
                            64'(o_resident_peak));
                check_field("prefetch_shed_total", 64'(want_rpt.prefetch_shed_total),
                            64'(o_prefetch_shed_total));
                check_field("pressure_level", 64'(want_rpt.pressure_level),
                            64'(o_pressure_level));
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired after %0d cycles without a beat", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command side. Every task below starts and ends right after a rising
    // edge. A command beat keeps valid high after acceptance, so the next
    // call either lowers it for a gap or puts the next beat straight on.
    // ------------------------------------------------------------------------
    task automatic send_command(input logic [2:0] cmd, input logic [2:0] pool,
                                input t_bytes amt, input logic [1:0] prio);
        int gap;
        gap = tx_idle_free ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd          <= cmd;
        i_pool         <= pool;
        i_amount       <= amt;
        i_priority_req <= prio;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_reports.push_back(account_command(cmd, pool, amt, prio));
        commands_sent++;
    endtask

    // Stop issuing and wait until every outstanding result has come back and
    // the pipeline is empty, so registers may be written safely.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; valid is left high for a following write.
    task automatic write_register(input t_cfg_idx idx, input t_bytes val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_RESIDENT_LIMIT)
            lim_resident = val;
        else
            lim_pool[int'(idx - CFG_POOL_BASE)] = val;
    endtask

    task automatic program_limits();
        write_register(CFG_RESIDENT_LIMIT, next_resident_limit);
        for (int p = 0; p < POOL_COUNT; p++)
            write_register(CFG_POOL_BASE + t_cfg_idx'(p), next_pool_limit[p]);
        i_cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    function automatic t_bytes pick_limit(input int style);
        case (style)
            LIM_ZERO: return '0;
            LIM_MAX:  return '1;
            LIM_WIDE: return t_bytes'({$urandom, $urandom});
            default:  return t_bytes'($urandom_range(100, 5000));
        endcase
    endfunction

    // Amounts are mostly a fraction of the addressed pool's limit so that
    // pools fill up and drain again; the rest hit zero, all ones, the exact
    // limit and arbitrary 48-bit values.
    function automatic t_bytes pick_amount(input logic [2:0] pool);
        t_bytes lim;
        lim = (pool < POOL_COUNT) ? lim_pool[pool] : lim_resident;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return t_bytes'({$urandom, $urandom});
            2:       return '1;
            3:       return lim;
            default: return t_bytes'({$urandom, $urandom} % (64'(lim) / 3 + 1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // All limits are zero after reset, so pressure is hard and every nonzero
    // reserve is refused.
    task automatic test_after_reset();
        send_command(CMD_QUERY, 3'd0, '0, PRIO_INTERACTION);
        send_command(CMD_TRY_RESERVE, 3'd1, t_bytes'(5), PRIO_PREFETCH);
        send_command(CMD_QUERY, INVALID_POOL, '0, PRIO_VISIBLE);
    endtask

    task automatic test_directed_commands();
        drain();
        next_resident_limit = t_bytes'(1000);
        for (int p = 0; p < POOL_COUNT; p++)
            next_pool_limit[p] = (p == DURABLE_POOL) ? t_bytes'(300) : t_bytes'(400);
        program_limits();
        // Fill pool 0 to its limit; it is then above its shedding line.
        send_command(CMD_TRY_RESERVE, 3'd0, t_bytes'(400), PRIO_INTERACTION);
        // Over the pool limit: sheds at prefetch and background only.
        send_command(CMD_TRY_RESERVE, 3'd0, t_bytes'(1), PRIO_PREFETCH);
        send_command(CMD_TRY_RESERVE, 3'd0, t_bytes'(1), PRIO_BACKGROUND);
        // A refused plain reserve counts nothing.
        send_command(CMD_RESERVE, 3'd0, t_bytes'(1), PRIO_PREFETCH);
        // A zero amount is granted without any change.
        send_command(CMD_RESERVE, 3'd1, '0, PRIO_VISIBLE);
        // Reach the resident limit exactly; pressure goes hard.
        send_command(CMD_RESERVE, 3'd1, t_bytes'(400), PRIO_VISIBLE);
        send_command(CMD_RESERVE, 3'd2, t_bytes'(200), PRIO_INTERACTION);
        // Pool 3 has room but the resident limit refuses it.
        send_command(CMD_TRY_RESERVE, 3'd3, t_bytes'(1), PRIO_PREFETCH);
        // The durable pool is outside the resident total.
        send_command(CMD_RESERVE, 3'd6, t_bytes'(300), PRIO_BACKGROUND);
        send_command(CMD_RESERVE, 3'd6, t_bytes'(1), PRIO_BACKGROUND);
        // Zero release, then a release larger than the pool holds.
        send_command(CMD_RELEASE, 3'd2, '0, PRIO_INTERACTION);
        send_command(CMD_RELEASE, 3'd2, t_bytes'(500), PRIO_INTERACTION);
        send_command(CMD_EVICT, 3'd6, '0, PRIO_INTERACTION);
        send_command(CMD_SHED, 3'd4, '0, PRIO_PREFETCH);
        // Spare command codes act as a query.
        send_command(CMD_SPARE_6, 3'd5, t_bytes'(77), PRIO_PREFETCH);
        send_command(CMD_SPARE_7, 3'd1, t_bytes'(77), PRIO_BACKGROUND);
        // An invalid pool changes nothing, even a prefetch try-reserve.
        send_command(CMD_TRY_RESERVE, INVALID_POOL, t_bytes'(9), PRIO_PREFETCH);
        // Emptying pool 0 does not bring pressure down: pool 1 is still above its shedding line.
        send_command(CMD_RELEASE, 3'd0, t_bytes'(400), PRIO_VISIBLE);
    endtask

    // A limit written below the current use keeps the use; reserves are
    // refused until enough has been released.
    task automatic test_lowered_limit();
        drain();
        write_register(CFG_POOL_BASE + t_cfg_idx'(1), t_bytes'(100));
        i_cfg_valid <= 1'b0;
        send_command(CMD_TRY_RESERVE, 3'd1, t_bytes'(10), PRIO_PREFETCH);
        send_command(CMD_RELEASE, 3'd1, t_bytes'(350), PRIO_INTERACTION);
        send_command(CMD_RESERVE, 3'd1, t_bytes'(50), PRIO_INTERACTION);
    endtask

    task automatic test_full_width();
        drain();
        next_resident_limit = '1;
        for (int p = 0; p < POOL_COUNT; p++)
            next_pool_limit[p] = '1;
        program_limits();
        send_command(CMD_RESERVE, 3'd6, '1, PRIO_INTERACTION);
        // Pool 1 still holds bytes, so a full-width reserve overflows the
        // resident limit.
        send_command(CMD_TRY_RESERVE, 3'd0, '1, PRIO_BACKGROUND);
        send_command(CMD_RELEASE, 3'd1, '1, PRIO_VISIBLE);
        send_command(CMD_RESERVE, 3'd0, '1, PRIO_INTERACTION);
        send_command(CMD_RELEASE, 3'd0, t_bytes'(48'hAAAA_AAAA_AAAA), PRIO_VISIBLE);
        send_command(CMD_RELEASE, 3'd6, t_bytes'(48'h5555_5555_5555), PRIO_VISIBLE);
    endtask

    // Phases of random traffic. The first phase runs with every limit at its
    // maximum and the second with every limit at zero; later phases mix
    // small, wide and extreme limits per register. Each phase also pauses
    // once at a random point until all results are back.
    task automatic test_random_traffic();
        int         pause_at;
        int         r;
        int         style;
        logic [2:0] cmd;
        logic [2:0] pool;
        logic [1:0] prio;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            for (int p = 0; p <= POOL_COUNT; p++) begin
                if (ph == 0)
                    style = LIM_MAX;
                else if (ph == 1)
                    style = LIM_ZERO;
                else
                    style = $urandom_range(0, 5);
                if (p == POOL_COUNT)
                    next_resident_limit = pick_limit(style);
                else
                    next_pool_limit[p] = pick_limit(style);
            end
            program_limits();
            tx_idle_free = ($urandom_range(0, 2) == 0);
            rx_idle_free = ($urandom_range(0, 2) == 0);
            pause_at = $urandom_range(1, PHASE_ITEMS - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == pause_at)
                    drain();
                r = $urandom_range(0, 99);
                if (r < 35)
                    cmd = CMD_TRY_RESERVE;
                else if (r < 50)
                    cmd = CMD_RESERVE;
                else if (r < 75)
                    cmd = CMD_RELEASE;
                else if (r < 82)
                    cmd = CMD_EVICT;
                else if (r < 89)
                    cmd = CMD_SHED;
                else if (r < 96)
                    cmd = CMD_QUERY;
                else
                    cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
                pool = ($urandom_range(0, 15) == 0) ? INVALID_POOL
                                                    : 3'($urandom_range(0, POOL_COUNT - 1));
                prio = 2'($urandom_range(0, 3));
                send_command(cmd, pool, pick_amount(pool), prio);
            end
        end
        tx_idle_free = 1'b0;
        rx_idle_free = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        lim_resident        = '0;
        shared_held         = '0;
        resident_peak_bytes = '0;
        prefetch_drops      = '0;
        for (int p = 0; p < POOL_COUNT; p++) begin
            lim_pool[p]     = '0;
            bytes_in_use[p] = '0;
            bytes_peak[p]   = '0;
            evictions[p]    = '0;
            sheds[p]        = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_after_reset();
        test_directed_commands();
        test_lowered_limit();
        test_full_width();
        test_random_traffic();

        // Let the last results come back, then give the pipeline a few more
        // cycles in case it produces something unexpected.
        i_in_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d predicted results never arrived", expected_reports.size());
            mismatches++;
        end

        $display("Sent %0d command beats and checked %0d result beats under %0d limit settings.",
                 commands_sent, reports_checked, settings_applied);
        $display("Mismatches seen: %0d", mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
